>>> src/lapr_pkg.sv
// ----------------------------------------------------------------------------
// lapr_pkg: shared types and constants for the byte PRNG
// Step counts, item kinds, sequencer states and the step unit result record.
// ----------------------------------------------------------------------------
package lapr_pkg;

   localparam int WARMUP_DRAWS   = 8;
   localparam int STEPS_PER_DRAW = 4;
   localparam int WARMUP_STEPS   = WARMUP_DRAWS * STEPS_PER_DRAW;
   localparam int CNT_W          = $clog2(WARMUP_STEPS + STEPS_PER_DRAW + 1);

   localparam int SEED_W  = 48;
   localparam int VALUE_W = 32;

   localparam logic [7:0] NEWEST_ODD = 8'h01;

   localparam logic KIND_SEED = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WARM,
      ST_DRAW
   } lapr_state_type;

   typedef struct packed {
      logic [7:0] new_byte;
      logic [7:0] mix_first;
      logic [7:0] mix_second;
      logic [7:0] out_byte;
   } lapr_step_type;

endpackage

>>> src/lapr_step.sv
// ----------------------------------------------------------------------------
// lapr_step: one byte step of the generator
// Computes the new LFSR byte, the two new mixer bytes and the output byte.
// ----------------------------------------------------------------------------
module lapr_step (
   input  logic [7:0]              oldest,
   input  logic [7:0]              newest,
   input  logic [7:0]              mix_first,
   input  logic [7:0]              mix_second,
   output lapr_pkg::lapr_step_type result
);
   import lapr_pkg::*;

   logic [7:0] fb;
   logic [7:0] nb;
   logic [7:0] m;
   logic [7:0] r;
   logic [7:0] n;

   always_comb begin
      fb = oldest ^ (oldest >> 1);
      nb = newest ^ fb ^ (newest >> 3) ^ (fb << 1);
      m  = mix_second + nb;
      r  = {m[6:0], m[7]} ^ {m[3:0], m[7:4]} ^ m;
      n  = mix_first + r;
      result.new_byte   = nb;
      result.mix_first  = m;
      result.mix_second = n;
      result.out_byte   = m ^ n;
   end

endmodule

>>> src/lfsr_arx_byte_prng.sv
// ----------------------------------------------------------------------------
// lfsr_arx_byte_prng: byte-wise xorshift LFSR with add-rotate-xor mixer
//
//   channel | dir | ports                         | content
//   req     | in  | req_tvalid/tready/tdata/tuser | tdata = seed, tuser = kind
//   rsp     | out | rsp_tvalid/tready/tdata       | tdata = value
//
// One byte step per cycle via one step unit, unless a draw waits on the output.
// A draw runs 4 steps after its accept; a seed runs WARMUP_DRAWS*4 steps.
// req_tready is high only while the sequencer is idle. A finished value waits
// in the output register; a later draw holds its last step until it is free.
// Reset is synchronous and restores the generator state to 0,0,0,0,0,1.
// ----------------------------------------------------------------------------
module lfsr_arx_byte_prng (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lapr_pkg::SEED_W-1:0]   req_tdata,  // seed[47:0]
   input  logic                          req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lapr_pkg::VALUE_W-1:0]  rsp_tdata   // value[31:0]
);
   import lapr_pkg::*;

   lapr_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [7:0]          shift_ff [4];
   logic [7:0]          shift_in [4];
   logic [7:0]          mix_a_ff, mix_a_in;
   logic [7:0]          mix_b_ff, mix_b_in;
   logic [VALUE_W-1:0]  word_ff, word_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lapr_step_type       step;
   logic                do_step;
   logic                out_free;
   logic                last_draw;

   lapr_step u_step (
      .oldest     (shift_ff[0]),
      .newest     (shift_ff[3]),
      .mix_first  (mix_a_ff),
      .mix_second (mix_b_ff),
      .result     (step)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      mix_a_in     = mix_a_ff;
      mix_b_in     = mix_b_ff;
      word_in      = word_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_free     = !rsp_valid_ff || rsp_tready;
      last_draw    = (cnt_ff == CNT_W'(STEPS_PER_DRAW - 1));
      do_step      = 1'b0;
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cnt_in = '0;
               if (req_tuser == KIND_SEED) begin
                  mix_a_in    = req_tdata[7:0];
                  mix_b_in    = req_tdata[15:8];
                  shift_in[0] = req_tdata[23:16];
                  shift_in[1] = req_tdata[31:24];
                  shift_in[2] = req_tdata[39:32];
                  shift_in[3] = req_tdata[47:40] | NEWEST_ODD;
                  state_in    = (WARMUP_STEPS == 0) ? ST_IDLE : ST_WARM;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_WARM: begin
            do_step = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WARMUP_STEPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAW: begin
            do_step = !last_draw || out_free;
            if (do_step) begin
               cnt_in  = cnt_ff + 1'b1;
               word_in = {step.out_byte, word_ff[VALUE_W-1:8]};
               if (last_draw) begin
                  rsp_data_in  = word_in;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_step) begin
         shift_in[0] = shift_ff[1];
         shift_in[1] = shift_ff[2];
         shift_in[2] = shift_ff[3];
         shift_in[3] = step.new_byte;
         mix_a_in    = step.mix_first;
         mix_b_in    = step.mix_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         shift_ff[0]  <= 8'h00;
         shift_ff[1]  <= 8'h00;
         shift_ff[2]  <= 8'h00;
         shift_ff[3]  <= 8'h01;
         mix_a_ff     <= 8'h00;
         mix_b_ff     <= 8'h00;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
         mix_a_ff     <= mix_a_in;
         mix_b_ff     <= mix_b_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
